@@ rtl/graph_component_labeler_macros.svh @@
// Assertion macros for the graph component labeler checker
`ifndef GRAPH_COMPONENT_LABELER_MACROS_SVH
`define GRAPH_COMPONENT_LABELER_MACROS_SVH

// Same-cycle implication
`define GCL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("graph_component_labeler: assertion failed");

// Next-cycle implication
`define GCL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("graph_component_labeler: assertion failed");

`endif

@@ rtl/gcl_pkg.sv @@
// Shared constants, types and functions of the graph component labeler
package gcl_pkg;

   localparam int MAX_NODES_DEF = 64;
   localparam int ID_W          = 6;
   localparam int ID_SLOTS      = 64;
   localparam int COMP_W        = 6;

   typedef struct packed {
      logic                any;
      logic [ID_SLOTS-1:0] onehot;
      logic [ID_W-1:0]     index;
   } pick_type;

   function automatic logic [ID_W-1:0] onehot_index(input logic [ID_SLOTS-1:0] oh);
      logic [ID_W-1:0] idx;
      idx = '0;
      for (int k = 0; k < ID_SLOTS; k++) begin
         if (oh[k]) begin
            idx = idx | ID_W'(k);
         end
      end
      return idx;
   endfunction

endpackage

@@ rtl/gcl_pick.sv @@
// Frontier picker: isolates the lowest pending node of the walk frontier
module gcl_pick (
   input  logic [gcl_pkg::ID_SLOTS-1:0] frontier,
   output gcl_pkg::pick_type            pick
);

   logic [gcl_pkg::ID_SLOTS-1:0] lowest;

   // two's complement trick keeps only the lowest set bit
   assign lowest      = frontier & (~frontier + gcl_pkg::ID_SLOTS'(1));
   assign pick.any    = |frontier;
   assign pick.onehot = lowest;
   assign pick.index  = gcl_pkg::onehot_index(lowest);

endmodule

@@ rtl/graph_component_labeler.sv @@
// Loading: one node loaded per cycle while busy is low; the item marked last raises busy.
// Walk: fetch and check each list entry, pop and expand each node reached, close each component
// and finish; each result then passes S_EMIT_RD, S_EMIT_LBL and S_EMIT_OUT, one strobe each.
// Results cannot be stalled; busy drops the cycle after the last label strobe.
// Reset clears the sequencer, counts and masks; memories keep contents, none is read unwritten.
module graph_component_labeler #(
   parameter int MAX_NODES = gcl_pkg::MAX_NODES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [gcl_pkg::ID_W-1:0]      req_node_id,
   input  logic [gcl_pkg::ID_SLOTS-1:0]  req_neighbour_mask,
   input  logic                          req_last_node,
   output logic                          rsp_valid,
   output logic [gcl_pkg::ID_W-1:0]      rsp_node_id_res,
   output logic [gcl_pkg::COMP_W-1:0]    rsp_component,
   output logic                          rsp_last_label
);

   localparam int AW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);

   typedef enum logic [7:0] {
      S_LOAD     = 8'b0000_0001,
      S_FETCH    = 8'b0000_0010,
      S_START    = 8'b0000_0100,
      S_POP      = 8'b0000_1000,
      S_EXPAND   = 8'b0001_0000,
      S_EMIT_RD  = 8'b0010_0000,
      S_EMIT_LBL = 8'b0100_0000,
      S_EMIT_OUT = 8'b1000_0000
   } state_type;

   state_type                      state_ff, state_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [CW-1:0]                  idx_ff, idx_in;
   logic [gcl_pkg::ID_SLOTS-1:0]   listed_ff, listed_in;
   logic [gcl_pkg::ID_SLOTS-1:0]   mark_ff, mark_in;
   logic [gcl_pkg::ID_SLOTS-1:0]   frontier_ff, frontier_in;
   logic [gcl_pkg::COMP_W-1:0]     comp_ff, comp_in;

   logic [gcl_pkg::ID_W-1:0]       order_mem [MAX_NODES];
   logic [gcl_pkg::ID_SLOTS-1:0]   adj_mem [gcl_pkg::ID_SLOTS];
   logic [gcl_pkg::COMP_W-1:0]     lbl_mem [gcl_pkg::ID_SLOTS];
   logic [gcl_pkg::ID_W-1:0]       order_q_ff;
   logic [gcl_pkg::ID_SLOTS-1:0]   adj_q_ff;
   logic [gcl_pkg::COMP_W-1:0]     lbl_q_ff;

   logic                           accept;
   logic                           room;
   logic                           last_emit;
   logic                           order_we, order_re, adj_re, lbl_we, lbl_re;
   logic [gcl_pkg::ID_SLOTS-1:0]   new_bits;
   logic [gcl_pkg::ID_SLOTS-1:0]   start_bit;
   gcl_pkg::pick_type              pick;

   gcl_pick u_pick (
      .frontier (frontier_ff),
      .pick     (pick)
   );

   assign accept    = start && (state_ff == S_LOAD);
   assign room      = count_ff < CW'(MAX_NODES);
   assign last_emit = (idx_ff + CW'(1)) == count_ff;
   assign new_bits  = adj_q_ff & listed_ff & ~mark_ff;
   assign start_bit = gcl_pkg::ID_SLOTS'(1) << order_q_ff;

   assign order_we = accept && room;
   assign order_re = (state_ff == S_FETCH && idx_ff != count_ff) || (state_ff == S_EMIT_RD);
   assign adj_re   = (state_ff == S_POP) && pick.any;
   assign lbl_we   = adj_re;
   assign lbl_re   = (state_ff == S_EMIT_LBL);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      listed_in   = listed_ff;
      mark_in     = mark_ff;
      frontier_in = frontier_ff;
      comp_in     = comp_ff;
      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (room) begin
                  count_in  = count_ff + CW'(1);
                  listed_in = listed_ff | (gcl_pkg::ID_SLOTS'(1) << req_node_id);
               end
               if (req_last_node) begin
                  idx_in   = '0;
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            if (idx_ff == count_ff) begin
               idx_in   = '0;
               state_in = S_EMIT_RD;
            end else begin
               state_in = S_START;
            end
         end
         S_START: begin
            // skip list entries already reached by an earlier walk
            if (mark_ff[order_q_ff]) begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_FETCH;
            end else begin
               frontier_in = start_bit;
               mark_in     = mark_ff | start_bit;
               state_in    = S_POP;
            end
         end
         S_POP: begin
            if (!pick.any) begin
               comp_in  = comp_ff + gcl_pkg::COMP_W'(1);
               idx_in   = idx_ff + CW'(1);
               state_in = S_FETCH;
            end else begin
               frontier_in = frontier_ff & ~pick.onehot;
               state_in    = S_EXPAND;
            end
         end
         S_EXPAND: begin
            frontier_in = frontier_ff | new_bits;
            mark_in     = mark_ff | new_bits;
            state_in    = S_POP;
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_LBL;
         end
         S_EMIT_LBL: begin
            state_in = S_EMIT_OUT;
         end
         S_EMIT_OUT: begin
            if (last_emit) begin
               // drop the run and get ready for the next graph
               count_in    = '0;
               idx_in      = '0;
               listed_in   = '0;
               mark_in     = '0;
               frontier_in = '0;
               comp_in     = '0;
               state_in    = S_LOAD;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_EMIT_RD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         count_ff    <= '0;
         idx_ff      <= '0;
         listed_ff   <= '0;
         mark_ff     <= '0;
         frontier_ff <= '0;
         comp_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         idx_ff      <= idx_in;
         listed_ff   <= listed_in;
         mark_ff     <= mark_in;
         frontier_ff <= frontier_in;
         comp_ff     <= comp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (order_we) begin
         order_mem[count_ff[AW-1:0]] <= req_node_id;
      end
      if (order_re) begin
         order_q_ff <= order_mem[idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (order_we) begin
         adj_mem[req_node_id] <= req_neighbour_mask;
      end
      if (adj_re) begin
         adj_q_ff <= adj_mem[pick.index];
      end
   end

   always_ff @(posedge clock) begin
      if (lbl_we) begin
         lbl_mem[pick.index] <= comp_ff;
      end
      if (lbl_re) begin
         lbl_q_ff <= lbl_mem[order_q_ff];
      end
   end

   assign busy            = (state_ff != S_LOAD);
   assign rsp_valid       = (state_ff == S_EMIT_OUT);
   assign rsp_node_id_res = order_q_ff;
   assign rsp_component   = lbl_q_ff;
   assign rsp_last_label  = last_emit;

endmodule

@@ rtl/gcl_checker.sv @@
// Port-level checker for the graph component labeler, bound to the top level
`include "graph_component_labeler_macros.svh"

module gcl_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_last_node,
   input logic rsp_valid,
   input logic rsp_last_label
);

   `GCL_ASSERT_IMP(a_rsp_only_busy, clock, reset, rsp_valid, busy)
   `GCL_ASSERT_NXT(a_last_starts_walk, clock, reset, start && !busy && req_last_node, busy && !rsp_valid)
   `GCL_ASSERT_NXT(a_plain_load_idle, clock, reset, start && !busy && !req_last_node, !busy && !rsp_valid)
   `GCL_ASSERT_NXT(a_final_label_ends, clock, reset, rsp_valid && rsp_last_label, !busy && !rsp_valid)
   `GCL_ASSERT_NXT(a_more_labels_stay, clock, reset, rsp_valid && !rsp_last_label, busy)

endmodule

bind graph_component_labeler gcl_checker u_gcl_checker (.*);

@@ sim/tb_graph_component_labeler.sv @@
// Self-checking testbench: random graphs loaded node by node, component labels checked in order
`timescale 1ns / 1ps

module tb_graph_component_labeler;

   localparam int         MAX_NODES   = gcl_pkg::MAX_NODES_DEF;
   localparam int         ID_W        = gcl_pkg::ID_W;
   localparam int         ID_SLOTS    = gcl_pkg::ID_SLOTS;
   localparam int         COMP_W      = gcl_pkg::COMP_W;
   localparam bit [6:0]   UNVISITED   = 7'h7f;
   localparam int         STALL_LIMIT = 20000;
   localparam int         DRAIN_CYCLES = 600;
   localparam int         TARGET_LOADS = 360;

   typedef struct {
      bit [ID_W-1:0]     id;
      bit [ID_SLOTS-1:0] mask;
      bit                last;
   } node_load_type;

   typedef struct {
      bit [ID_W-1:0]   id;
      bit [COMP_W-1:0] component;
      bit              last;
   } node_label_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [ID_W-1:0]     req_node_id = '0;
   logic [ID_SLOTS-1:0] req_neighbour_mask = '0;
   logic                req_last_node = 1'b0;
   logic                rsp_valid;
   logic [ID_W-1:0]     rsp_node_id_res;
   logic [COMP_W-1:0]   rsp_component;
   logic                rsp_last_label;

   node_load_type  pending_loads[$];
   node_label_type expected_labels[$];
   int             total_loads = 0;
   int             loads_done = 0;
   int             errors = 0;
   int             stall_cycles = 0;

   // predictor state
   bit [ID_W-1:0]     listed_ids[MAX_NODES];
   bit [ID_SLOTS-1:0] adj_rows[ID_SLOTS];
   int                listed_count = 0;

   graph_component_labeler dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_node_id        (req_node_id),
      .req_neighbour_mask (req_neighbour_mask),
      .req_last_node      (req_last_node),
      .rsp_valid          (rsp_valid),
      .rsp_node_id_res    (rsp_node_id_res),
      .rsp_component      (rsp_component),
      .rsp_last_label     (rsp_last_label)
   );

   always #1 clock = ~clock;

   // Store one node; on the last one, flood-fill components and queue the labels.
   function automatic void load_and_label(input bit [ID_W-1:0] id,
                                          input bit [ID_SLOTS-1:0] mask,
                                          input bit last);
      bit [ID_SLOTS-1:0] listed;
      bit [ID_SLOTS-1:0] seen;
      bit [ID_SLOTS-1:0] front;
      bit [ID_SLOTS-1:0] reach;
      bit [6:0]          labels[ID_SLOTS];
      bit [COMP_W-1:0]   comp;
      bit [ID_W-1:0]     root;
      node_label_type    lbl;
      if (listed_count < MAX_NODES) begin
         listed_ids[listed_count] = id;
         adj_rows[id] = mask;
         listed_count++;
      end
      if (!last) return;
      listed = '0;
      seen = '0;
      comp = '0;
      for (int k = 0; k < ID_SLOTS; k++) labels[k] = UNVISITED;
      for (int i = 0; i < listed_count; i++) listed[listed_ids[i]] = 1'b1;
      for (int i = 0; i < listed_count; i++) begin
         root = listed_ids[i];
         if (labels[root] != UNVISITED) continue;
         front = '0;
         front[root] = 1'b1;
         while (front != '0) begin
            reach = '0;
            seen |= front;
            for (int k = 0; k < ID_SLOTS; k++) begin
               if (front[k]) begin
                  labels[k] = {1'b0, comp};
                  reach |= adj_rows[k];
               end
            end
            front = reach & listed & ~seen;
         end
         comp++;
      end
      for (int i = 0; i < listed_count; i++) begin
         lbl.id = listed_ids[i];
         lbl.component = labels[listed_ids[i]][COMP_W-1:0];
         lbl.last = (i == listed_count - 1);
         expected_labels.insert(expected_labels.size(), lbl);
      end
      listed_count = 0;
   endfunction

   task automatic queue_node(input bit [ID_W-1:0] id, input bit [ID_SLOTS-1:0] mask,
                             input bit last);
      node_load_type item;
      item.id = id;
      item.mask = mask;
      item.last = last;
      pending_loads.insert(pending_loads.size(), item);
   endtask

   // n nodes (distinct unless noisy repeats one) with random edges, then extra nodes past a full list
   task automatic queue_random_graph(input int n, input bit noisy, input int extra);
      bit [ID_W-1:0]     ids[ID_SLOTS];
      bit [ID_SLOTS-1:0] masks[ID_SLOTS];
      bit [ID_SLOTS-1:0] listed;
      bit [ID_W-1:0]     tmp;
      int                j;
      int                pct;
      bit                sym;
      for (int i = 0; i < ID_SLOTS; i++) ids[i] = ID_W'(i);
      for (int i = ID_SLOTS - 1; i > 0; i--) begin
         j = $urandom_range(i, 0);
         tmp = ids[i];
         ids[i] = ids[j];
         ids[j] = tmp;
      end
      listed = '0;
      for (int i = 0; i < n; i++) listed[ids[i]] = 1'b1;
      if (n > 16) pct = $urandom_range(6, 1);
      else pct = $urandom_range(2) == 0 ? 10 : ($urandom_range(1) ? 30 : 60);
      sym = 1'($urandom_range(1));
      for (int i = 0; i < n; i++) masks[i] = '0;
      for (int a = 0; a < n; a++) begin
         for (int b = 0; b < n; b++) begin
            if (a != b && $urandom_range(99) < pct) begin
               masks[a][ids[b]] = 1'b1;
               if (sym) masks[b][ids[a]] = 1'b1;
            end
         end
      end
      if (noisy) begin
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
               0: masks[i] |= {$urandom, $urandom} & ~listed;
               1: masks[i] = '1;
               2: masks[i] = {$urandom, $urandom};
               default: ;
            endcase
         end
         // repeat an earlier node number
         if (n > 1 && $urandom_range(1)) ids[n-1] = ids[$urandom_range(n - 2, 0)];
      end
      for (int i = 0; i < n; i++) queue_node(ids[i], masks[i], (i == n - 1) && (extra == 0));
      for (int i = 0; i < extra; i++)
         queue_node(ID_W'($urandom_range(ID_SLOTS - 1)), {$urandom, $urandom}, i == extra - 1);
   endtask

   initial begin : stimulus
      int graph_no;
      // lone nodes at both ends of the id range
      queue_node(6'd0, 64'h0, 1'b1);
      queue_node(6'd63, '1, 1'b1);
      // one-way edge: later node points back at an earlier one
      queue_node(6'd5, 64'h0, 1'b0);
      queue_node(6'd9, 64'h1 << 5, 1'b0);
      queue_node(6'd12, 64'h0, 1'b1);
      // extreme ids joined, unlisted neighbours ignored, full mask on a late node
      queue_node(6'd63, (64'h1 << 0) | (64'h1 << 40), 1'b0);
      queue_node(6'd0, 64'h1 << 63, 1'b0);
      queue_node(6'd42, '1, 1'b1);
      // repeated node: second mask replaces the first
      queue_node(6'd7, 64'h1 << 8, 1'b0);
      queue_node(6'd8, 64'h0, 1'b0);
      queue_node(6'd7, 64'h0, 1'b0);
      queue_node(6'd30, 64'h1 << 31, 1'b0);
      queue_node(6'd31, 64'h1 << 30, 1'b1);
      // chain with alternating noise in the unlisted bits
      queue_node(6'd1, (64'h1 << 2) | 64'haaaa_aaaa_0000_0000, 1'b0);
      queue_node(6'd2, (64'h1 << 3) | 64'h5555_5555_0000_0000, 1'b0);
      queue_node(6'd3, 64'h1 << 4, 1'b0);
      queue_node(6'd4, 64'h0, 1'b1);

      graph_no = 0;
      while (pending_loads.size() < TARGET_LOADS) begin
         if (graph_no == 4) queue_random_graph(64, 1'b0, 0);
         else if (graph_no == 14) queue_random_graph(64, 1'b0, 3);
         else queue_random_graph($urandom_range(10, 1), $urandom_range(4) == 0, 0);
         graph_no++;
      end
      total_loads = pending_loads.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (loads_done < total_loads || expected_labels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("PASS graph_component_labeler");
      end else begin
         $display("FAIL graph_component_labeler");
      end
      $finish;
   end

   always @(posedge clock) begin : driver
      node_load_type nxt;
      int            idle_pct;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            load_and_label(req_node_id, req_neighbour_mask, req_last_node);
            loads_done = loads_done + 1;
         end
         if (loads_done * 3 < total_loads) idle_pct = 34;
         else if (loads_done * 3 < total_loads * 2) idle_pct = 70;
         else idle_pct = 0;
         // advance only once the current transaction is taken
         if (!start || !busy) begin
            if (pending_loads.size() != 0 && $urandom_range(99) >= idle_pct) begin
               nxt = pending_loads.pop_front();
               start <= 1'b1;
               req_node_id <= nxt.id;
               req_neighbour_mask <= nxt.mask;
               req_last_node <= nxt.last;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      node_label_type want;
      if (!reset && rsp_valid) begin
         if (expected_labels.size() == 0) begin
            $display("%0t: unexpected label: expected none, got node %0d component %0d last %0d",
                     $time, rsp_node_id_res, rsp_component, rsp_last_label);
            errors++;
         end else begin
            want = expected_labels.pop_front();
            if (rsp_node_id_res !== want.id) begin
               $display("%0t: node_id_res expected %0d got %0d", $time, want.id, rsp_node_id_res);
               errors++;
            end
            if (rsp_component !== want.component) begin
               $display("%0t: component of node %0d expected %0d got %0d", $time, want.id,
                        want.component, rsp_component);
               errors++;
            end
            if (rsp_last_label !== want.last) begin
               $display("%0t: last_label of node %0d expected %0d got %0d", $time, want.id,
                        want.last, rsp_last_label);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("FAIL graph_component_labeler");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
